/* design/dcsg_pkg.sv */
// Shared types, command codes and helpers for the display command stream generator.
package dcsg_pkg;

  localparam int DEF_PANEL_WIDTH  = 240;
  localparam int DEF_PANEL_HEIGHT = 320;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 4;

  // Panel controller command bytes
  localparam logic [7:0] CMD_CASET  = 8'h2A;
  localparam logic [7:0] CMD_PASET  = 8'h2B;
  localparam logic [7:0] CMD_RAMWR  = 8'h2C;
  localparam logic [7:0] CMD_MADCTL = 8'h36;
  localparam logic [7:0] CMD_INVON  = 8'h21;
  localparam logic [7:0] CMD_INVOFF = 8'h20;

  // Memory access control bits
  localparam logic [7:0] MAD_MY  = 8'h80;
  localparam logic [7:0] MAD_MX  = 8'h40;
  localparam logic [7:0] MAD_MV  = 8'h20;
  localparam logic [7:0] MAD_BGR = 8'h08;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_FILL_RECT = 3'd1,
    ACT_FILL_SCR  = 3'd2,
    ACT_WINDOW    = 3'd3,
    ACT_PIXEL     = 3'd4,
    ACT_ROTATE    = 3'd5,
    ACT_INVERT    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    JOB_HEADER = 2'd0,
    JOB_PAIR   = 2'd1,
    JOB_ROTATE = 2'd2,
    JOB_INVERT = 2'd3
  } job_kind_t;

  // Header: w0 x0, w1 x1, w2 y0, w3 y1. Pair: w0 colour. Rotate/invert: code.
  typedef struct packed {
    job_kind_t           kind;
    logic [COORD_W-1:0]  w0;
    logic [COORD_W-1:0]  w1;
    logic [COORD_W-1:0]  w2;
    logic [COORD_W-1:0]  w3;
    logic [7:0]          code;
    logic                done;
  } job_t;

  function automatic logic [IDX_W-1:0] last_idx(input job_kind_t kind);
    logic [IDX_W-1:0] r;
    unique case (kind)
      JOB_HEADER: r = IDX_W'(10);
      JOB_PAIR:   r = IDX_W'(1);
      JOB_ROTATE: r = IDX_W'(1);
      JOB_INVERT: r = IDX_W'(0);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/display_command_stream_generator.sv */
// Top level of the display command stream generator: front end, job queue, serializer.
// A byte-producing action reaches the output via the job queue, job and output registers.
// Throughput: one output byte per cycle, set by the serializer, unless the receiver
//   stalls; a fill tick gives two bytes, a header eleven, rotate two, invert one.
//   Input transfers continue while the job queue (QUEUE_DEPTH entries) has room.
// Reset: rst clears the queue and the output register, drops pending fill pixels,
//   and restores the logical size to PANEL_WIDTH by PANEL_HEIGHT.
module display_command_stream_generator #(
  parameter int PANEL_WIDTH  = dcsg_pkg::DEF_PANEL_WIDTH,   // 1 .. 65535
  parameter int PANEL_HEIGHT = dcsg_pkg::DEF_PANEL_HEIGHT,  // 1 .. 65535
  parameter int QUEUE_DEPTH  = dcsg_pkg::DEF_QUEUE_DEPTH    // 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  // Action input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] x_start, [31:16] y_start, [47:32] rect_width, [63:48] rect_height,
  // [79:64] colour, [81:80] rotation, [82] invert_on, [87:83] zero
  input  logic [87:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  // Byte output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  // [0] is_data, [1] fill_done
  output logic [1:0]  m_axis_tuser,
  // last byte caused by one action
  output logic        m_axis_tlast
);

  dcsg_pkg::job_t push_job;
  dcsg_pkg::job_t head_job;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  // Classify each action and update fill and geometry state on its transfer.
  dcsg_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .action      (s_axis_tuser),
    .x_start     (s_axis_tdata[15:0]),
    .y_start     (s_axis_tdata[31:16]),
    .rect_width  (s_axis_tdata[47:32]),
    .rect_height (s_axis_tdata[63:48]),
    .colour      (s_axis_tdata[79:64]),
    .rotation    (s_axis_tdata[81:80]),
    .invert_on   (s_axis_tdata[82]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // Hold jobs so the front end keeps taking actions while bytes drain.
  dcsg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  // Advance through each job one byte per cycle into the output register, unless stalled.
  dcsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_job       (head_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .is_data     (m_axis_tuser[0]),
    .last_of_run (m_axis_tlast),
    .fill_done   (m_axis_tuser[1])
  );

endmodule

/* design/dcsg_front.sv */
// Front end: accept actions, keep fill and geometry state, emit byte jobs.
module dcsg_front #(
  parameter int PANEL_WIDTH  = dcsg_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = dcsg_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     action,
  input  logic [dcsg_pkg::COORD_W-1:0]   x_start,
  input  logic [dcsg_pkg::COORD_W-1:0]   y_start,
  input  logic [dcsg_pkg::COORD_W-1:0]   rect_width,
  input  logic [dcsg_pkg::COORD_W-1:0]   rect_height,
  input  logic [15:0]                    colour,
  input  logic [1:0]                     rotation,
  input  logic                           invert_on,
  input  logic                           q_full,
  output logic                           q_push,
  output dcsg_pkg::job_t                 q_job
);

  logic [31:0] pixels_left;
  logic [15:0] fill_colour;
  logic [15:0] logical_width;
  logic [15:0] logical_height;

  logic        accept;
  logic [15:0] x0, y0, w, h;
  logic        produce;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    x0 = x_start;
    y0 = y_start;
    w  = rect_width;
    h  = rect_height;
    if (action == dcsg_pkg::ACT_FILL_SCR) begin
      x0 = '0;
      y0 = '0;
      w  = logical_width;
      h  = logical_height;
    end
  end

  always_comb begin
    produce    = 1'b0;
    q_job      = '0;
    q_job.w0   = x0;
    q_job.w1   = x0 + w - 16'd1;
    q_job.w2   = y0;
    q_job.w3   = y0 + h - 16'd1;
    unique case (action)
      dcsg_pkg::ACT_TICK: begin
        produce    = (pixels_left != '0);
        q_job.kind = dcsg_pkg::JOB_PAIR;
        q_job.w0   = fill_colour;
        q_job.done = (pixels_left == 32'd1);
      end
      dcsg_pkg::ACT_FILL_RECT, dcsg_pkg::ACT_FILL_SCR: begin
        produce    = 1'b1;
        q_job.kind = dcsg_pkg::JOB_HEADER;
        q_job.done = (w == '0) || (h == '0);
      end
      dcsg_pkg::ACT_WINDOW: begin
        produce    = 1'b1;
        q_job.kind = dcsg_pkg::JOB_HEADER;
      end
      dcsg_pkg::ACT_PIXEL: begin
        produce    = 1'b1;
        q_job.kind = dcsg_pkg::JOB_PAIR;
        q_job.w0   = colour;
      end
      dcsg_pkg::ACT_ROTATE: begin
        produce    = 1'b1;
        q_job.kind = dcsg_pkg::JOB_ROTATE;
        unique case (rotation)
          2'd0:    q_job.code = dcsg_pkg::MAD_MX | dcsg_pkg::MAD_BGR;
          2'd1:    q_job.code = dcsg_pkg::MAD_MV | dcsg_pkg::MAD_BGR;
          2'd2:    q_job.code = dcsg_pkg::MAD_MY | dcsg_pkg::MAD_BGR;
          default: q_job.code = dcsg_pkg::MAD_MY | dcsg_pkg::MAD_MX |
                                dcsg_pkg::MAD_MV | dcsg_pkg::MAD_BGR;
        endcase
      end
      dcsg_pkg::ACT_INVERT: begin
        produce    = 1'b1;
        q_job.kind = dcsg_pkg::JOB_INVERT;
        q_job.code = invert_on ? dcsg_pkg::CMD_INVON : dcsg_pkg::CMD_INVOFF;
      end
      default: produce = 1'b0;
    endcase
  end

  assign q_push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left    <= '0;
      fill_colour    <= '0;
      logical_width  <= 16'(PANEL_WIDTH);
      logical_height <= 16'(PANEL_HEIGHT);
    end else if (accept) begin
      unique case (action)
        dcsg_pkg::ACT_TICK: begin
          if (pixels_left != '0) pixels_left <= pixels_left - 32'd1;
        end
        dcsg_pkg::ACT_FILL_RECT, dcsg_pkg::ACT_FILL_SCR: begin
          pixels_left <= {16'd0, w} * {16'd0, h};
          fill_colour <= colour;
        end
        dcsg_pkg::ACT_WINDOW: pixels_left <= '0;
        dcsg_pkg::ACT_ROTATE: begin
          if (rotation[0]) begin
            logical_width  <= 16'(PANEL_HEIGHT);
            logical_height <= 16'(PANEL_WIDTH);
          end else begin
            logical_width  <= 16'(PANEL_WIDTH);
            logical_height <= 16'(PANEL_HEIGHT);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* design/dcsg_fifo.sv */
// Short job queue between the front end and the byte serializer.
module dcsg_fifo #(
  parameter int DEPTH = dcsg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcsg_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output dcsg_pkg::job_t dout,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dcsg_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

/* design/dcsg_back.sv */
// Back end: serialize queued jobs into flagged bytes behind an output register.
module dcsg_back (
  input  logic           clk,
  input  logic           rst,
  input  dcsg_pkg::job_t q_job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           is_data,
  output logic           last_of_run,
  output logic           fill_done
);

  dcsg_pkg::job_t              job;
  logic                        job_valid;
  logic [dcsg_pkg::IDX_W-1:0]  idx;

  logic       out_load;
  logic       at_last;
  logic [7:0] byte_next;
  logic       data_next;
  logic       done_next;

  assign at_last  = (idx == dcsg_pkg::last_idx(job.kind));
  assign out_load = job_valid && (!out_valid || out_ready);
  assign q_pop    = !q_empty && (!job_valid || (out_load && at_last));

  always_comb begin
    byte_next = '0;
    data_next = 1'b1;
    done_next = 1'b0;
    unique case (job.kind)
      dcsg_pkg::JOB_HEADER: begin
        unique case (idx)
          4'd0:  begin byte_next = dcsg_pkg::CMD_CASET; data_next = 1'b0; end
          4'd1:  byte_next = job.w0[15:8];
          4'd2:  byte_next = job.w0[7:0];
          4'd3:  byte_next = job.w1[15:8];
          4'd4:  byte_next = job.w1[7:0];
          4'd5:  begin byte_next = dcsg_pkg::CMD_PASET; data_next = 1'b0; end
          4'd6:  byte_next = job.w2[15:8];
          4'd7:  byte_next = job.w2[7:0];
          4'd8:  byte_next = job.w3[15:8];
          4'd9:  byte_next = job.w3[7:0];
          4'd10: begin
            byte_next = dcsg_pkg::CMD_RAMWR;
            data_next = 1'b0;
            done_next = job.done;
          end
          default: byte_next = '0;
        endcase
      end
      dcsg_pkg::JOB_PAIR: begin
        byte_next = idx[0] ? job.w0[7:0] : job.w0[15:8];
        done_next = idx[0] && job.done;
      end
      dcsg_pkg::JOB_ROTATE: begin
        byte_next = idx[0] ? job.code : dcsg_pkg::CMD_MADCTL;
        data_next = idx[0];
      end
      dcsg_pkg::JOB_INVERT: begin
        byte_next = job.code;
        data_next = 1'b0;
      end
      default: byte_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) job <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (out_load) begin
      if (at_last) job_valid <= 1'b0;
      else         idx       <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= byte_next;
      is_data     <= data_next;
      last_of_run <= at_last;
      fill_done   <= done_next;
    end
  end

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill_done |-> last_of_run)
    else $error("fill_done raised on a byte that does not close its run");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx <= dcsg_pkg::last_idx(job.kind))
    else $error("byte index ran past the end of its job");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !job_valid || (out_load && at_last))
    else $error("job popped while the current job still has bytes");

  a_cmd_flag: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.kind == dcsg_pkg::JOB_INVERT |-> !data_next && idx == '0)
    else $error("invert job must be one command byte");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the display command stream generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code outside the defined set; the block must swallow it silently
  localparam logic [2:0] ACT_RESERVED = 3'd7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLDOFF_CYCLES = 400;

  // One expected byte on the output stream
  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
    logic       done;
  } spi_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] x_start, [31:16] y_start, [47:32] rect_width, [63:48] rect_height,
  // [79:64] colour, [81:80] rotation, [82] invert_on, [87:83] zero
  logic [87:0] s_axis_tdata = '0;
  // [2:0] action
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] out_byte
  logic [7:0]  m_axis_tdata;
  // [0] is_data, [1] fill_done
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Expected output bytes, oldest first
  spi_byte_t expected_bytes[$];

  // Shadow of the block state, updated at each input transfer
  logic [31:0] fill_pending = '0;
  logic [15:0] fill_rgb     = '0;
  logic [15:0] view_w       = 16'(dcsg_pkg::DEF_PANEL_WIDTH);
  logic [15:0] view_h       = 16'(dcsg_pkg::DEF_PANEL_HEIGHT);

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_until    = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int actions_sent  = 0;
  int busy_actions  = 0;
  int bytes_checked = 0;
  int fills_done    = 0;

  display_command_stream_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: hold tready low through a requested hold-off window, otherwise
  // stall at random with the current phase's probability.
  always @(posedge clk) begin
    if (cycle_count < hold_until) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] value, logic is_data, logic last,
                                    logic done);
    spi_byte_t b;
    b.value   = value;
    b.is_data = is_data;
    b.last    = last;
    b.done    = done;
    expected_bytes.push_back(b);
  endfunction

  // Address window header: column range, page range, then memory write.
  // End coordinates wrap at 16 bits, so a zero size gives 0xFFFF past the start.
  function automatic void push_window(logic [15:0] x0, logic [15:0] y0, logic [15:0] w,
                                      logic [15:0] h, logic done);
    logic [15:0] x1;
    logic [15:0] y1;
    x1 = x0 + w - 16'd1;
    y1 = y0 + h - 16'd1;
    push_byte(dcsg_pkg::CMD_CASET, 1'b0, 1'b0, 1'b0);
    push_byte(x0[15:8], 1'b1, 1'b0, 1'b0);
    push_byte(x0[7:0],  1'b1, 1'b0, 1'b0);
    push_byte(x1[15:8], 1'b1, 1'b0, 1'b0);
    push_byte(x1[7:0],  1'b1, 1'b0, 1'b0);
    push_byte(dcsg_pkg::CMD_PASET, 1'b0, 1'b0, 1'b0);
    push_byte(y0[15:8], 1'b1, 1'b0, 1'b0);
    push_byte(y0[7:0],  1'b1, 1'b0, 1'b0);
    push_byte(y1[15:8], 1'b1, 1'b0, 1'b0);
    push_byte(y1[7:0],  1'b1, 1'b0, 1'b0);
    push_byte(dcsg_pkg::CMD_RAMWR, 1'b0, 1'b1, done);
  endfunction

  function automatic void predict_action(logic [2:0] act, logic [15:0] x0, logic [15:0] y0,
                                         logic [15:0] w, logic [15:0] h, logic [15:0] col,
                                         logic [1:0] rot, logic inv);
    int          queued;
    logic [31:0] count;
    logic [7:0]  mad;
    queued = expected_bytes.size();
    case (act)
      dcsg_pkg::ACT_TICK: begin
        // Tick: send one pixel of a pending fill; nothing pending, nothing sent
        if (fill_pending != 0) begin
          fill_pending = fill_pending - 1;
          push_byte(fill_rgb[15:8], 1'b1, 1'b0, 1'b0);
          push_byte(fill_rgb[7:0], 1'b1, 1'b1, fill_pending == 0);
        end
      end
      dcsg_pkg::ACT_FILL_RECT, dcsg_pkg::ACT_FILL_SCR: begin
        // Fill screen ignores the input geometry and uses the current view size
        if (act == dcsg_pkg::ACT_FILL_SCR) begin
          x0 = '0;
          y0 = '0;
          w  = view_w;
          h  = view_h;
        end
        count = {16'h0, w} * {16'h0, h};
        fill_pending = count;
        fill_rgb     = col;
        push_window(x0, y0, w, h, count == 0);
      end
      dcsg_pkg::ACT_WINDOW: begin
        fill_pending = '0;
        push_window(x0, y0, w, h, 1'b0);
      end
      dcsg_pkg::ACT_PIXEL: begin
        push_byte(col[15:8], 1'b1, 1'b0, 1'b0);
        push_byte(col[7:0], 1'b1, 1'b1, 1'b0);
      end
      dcsg_pkg::ACT_ROTATE: begin
        case (rot)
          2'd0:    mad = dcsg_pkg::MAD_MX | dcsg_pkg::MAD_BGR;
          2'd1:    mad = dcsg_pkg::MAD_MV | dcsg_pkg::MAD_BGR;
          2'd2:    mad = dcsg_pkg::MAD_MY | dcsg_pkg::MAD_BGR;
          default: mad = dcsg_pkg::MAD_MY | dcsg_pkg::MAD_MX |
                         dcsg_pkg::MAD_MV | dcsg_pkg::MAD_BGR;
        endcase
        // Odd quarter turns are landscape: swap the view dimensions
        view_w = rot[0] ? 16'(dcsg_pkg::DEF_PANEL_HEIGHT)
                        : 16'(dcsg_pkg::DEF_PANEL_WIDTH);
        view_h = rot[0] ? 16'(dcsg_pkg::DEF_PANEL_WIDTH)
                        : 16'(dcsg_pkg::DEF_PANEL_HEIGHT);
        push_byte(dcsg_pkg::CMD_MADCTL, 1'b0, 1'b0, 1'b0);
        push_byte(mad, 1'b1, 1'b1, 1'b0);
      end
      dcsg_pkg::ACT_INVERT: begin
        push_byte(inv ? dcsg_pkg::CMD_INVON : dcsg_pkg::CMD_INVOFF, 1'b0, 1'b1, 1'b0);
      end
      default: begin
      end
    endcase
    actions_sent++;
    if (expected_bytes.size() > queued) busy_actions++;
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin
    spi_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte 'h%0h with no transfer expected", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.value, m_axis_tdata);
        check_field("is_data", 8'(want.is_data), 8'(m_axis_tuser[0]));
        check_field("fill_done", 8'(want.done), 8'(m_axis_tuser[1]));
        check_field("last_of_run", 8'(want.last), 8'(m_axis_tlast));
        bytes_checked++;
        if (want.done) fills_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Offer one action after a random idle gap; predict once it is accepted.
  task automatic send_action(logic [2:0] act, logic [15:0] x0, logic [15:0] y0,
                             logic [15:0] w, logic [15:0] h, logic [15:0] col,
                             logic [1:0] rot, logic inv);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, inv, rot, col, h, w, y0, x0};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    predict_action(act, x0, y0, w, h, col, rot, inv);
  endtask

  // Send with the given size and random everything else
  task automatic send_sized(logic [2:0] act, logic [15:0] w, logic [15:0] h);
    send_action(act, 16'($urandom), 16'($urandom), w, h, 16'($urandom),
                2'($urandom), 1'($urandom));
  endtask

  // Pixel, rotate or invert: none of these may disturb a pending fill
  task automatic send_side_action();
    case ($urandom_range(2))
      0:       send_sized(dcsg_pkg::ACT_PIXEL, 16'($urandom), 16'($urandom));
      1:       send_sized(dcsg_pkg::ACT_ROTATE, 16'($urandom), 16'($urandom));
      default: send_sized(dcsg_pkg::ACT_INVERT, 16'($urandom), 16'($urandom));
    endcase
  endtask

  // Drop valid and wait for every expected byte to come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic test_edge_cases();
    int r;
    send_action(dcsg_pkg::ACT_INVERT, '0, '0, '0, '0, '0, 2'd0, 1'b1);
    send_action(dcsg_pkg::ACT_INVERT, '1, '1, '1, '1, '1, 2'd3, 1'b0);
    for (r = 1; r <= 4; r++) begin
      send_action(dcsg_pkg::ACT_ROTATE, '0, '0, '0, '0, '0, 2'(r), 1'b0);
    end
    send_action(dcsg_pkg::ACT_PIXEL, '0, '0, '0, '0, 16'hFFFF, 2'd0, 1'b0);
    // Idle tick and the reserved action give no bytes
    send_action(dcsg_pkg::ACT_TICK, '1, '1, '1, '1, '1, 2'd3, 1'b1);
    send_action(ACT_RESERVED, '1, '1, '1, '1, '1, 2'd3, 1'b1);
    // Window ends wrapping around at 16 bits in both directions
    send_action(dcsg_pkg::ACT_WINDOW, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_WINDOW, '1, '1, '1, '1, '1, 2'd3, 1'b1);
    // Empty fills flag completion on the memory write command
    send_action(dcsg_pkg::ACT_FILL_RECT, 16'h1234, 16'hABCD, 16'd0, 16'd5,
                16'hF800, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_FILL_RECT, 16'h4321, 16'h0001, 16'd3, 16'd0,
                16'h07E0, 2'd0, 1'b0);
    // Single pixel fill in the last column
    send_action(dcsg_pkg::ACT_FILL_RECT, 16'hFFFF, 16'h8000, 16'd1, 16'd1,
                16'hA5C3, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    // Side actions in the middle of a fill leave it pending
    send_action(dcsg_pkg::ACT_FILL_RECT, 16'd10, 16'd20, 16'd2, 16'd2,
                16'h07E0, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_PIXEL, '0, '0, '0, '0, 16'h1234, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_ROTATE, '0, '0, '0, '0, '0, 2'd1, 1'b0);
    send_action(dcsg_pkg::ACT_INVERT, '0, '0, '0, '0, '0, 2'd0, 1'b1);
    repeat (3) send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    // Full 32-bit pixel count, then a new window throws it away
    send_action(dcsg_pkg::ACT_FILL_RECT, 16'h0001, 16'h0002, '1, '1,
                16'h001F, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_WINDOW, 16'd5, 16'd6, 16'd7, 16'd8, '0, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    // Fill screen in landscape picks up the swapped size
    send_action(dcsg_pkg::ACT_FILL_SCR, '1, '1, '1, '1, 16'hC618, 2'd0, 1'b0);
    send_action(dcsg_pkg::ACT_TICK, '0, '0, '0, '0, '0, 2'd0, 1'b0);
    wait_drained();
  endtask

  // Mostly complete fills with random content; the rest windows, full-screen
  // fills and raw noise over the whole field range.
  task automatic test_random_traffic(int tx_pct, int rx_pct, int n);
    int target;
    int kind;
    int w;
    int h;
    int pix;
    int k;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = busy_actions + n;
    while (busy_actions < target) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 4);
        h = $urandom_range(0, 4);
        send_sized(dcsg_pkg::ACT_FILL_RECT, 16'(w), 16'(h));
        pix = w * h;
        // Cut some fills short; the next window or fill must discard the rest
        if ($urandom_range(6) == 0) pix = $urandom_range(pix);
        for (k = 0; k < pix; k++) begin
          if ($urandom_range(6) == 0) send_side_action();
          send_sized(dcsg_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
        end
        if ($urandom_range(2) == 0) begin
          send_sized(dcsg_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
        end
      end else if (kind < 72) begin
        send_sized(dcsg_pkg::ACT_WINDOW, 16'($urandom), 16'($urandom));
        repeat ($urandom_range(4)) begin
          send_sized(dcsg_pkg::ACT_PIXEL, 16'($urandom), 16'($urandom));
        end
      end else if (kind < 76) begin
        send_sized(dcsg_pkg::ACT_FILL_SCR, 16'($urandom), 16'($urandom));
        repeat ($urandom_range(3)) begin
          send_sized(dcsg_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
        end
      end else begin
        send_action(3'($urandom_range(7)), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
      end
    end
    wait_drained();
  endtask

  // Hold the receiver off while headers keep coming so the queue backs up
  task automatic test_receiver_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_until   = cycle_count + HOLDOFF_CYCLES;
    repeat (6) begin
      send_sized(dcsg_pkg::ACT_WINDOW, 16'($urandom), 16'($urandom));
      send_sized(dcsg_pkg::ACT_FILL_RECT, 16'($urandom_range(1, 3)),
                 16'($urandom_range(1, 3)));
    end
    wait_drained();
  endtask

  // Let the output run dry mid-fill, then resume the same fill
  task automatic test_drain_pause();
    tx_idle_pct  = 14;
    rx_stall_pct = 14;
    send_sized(dcsg_pkg::ACT_FILL_RECT, 16'd3, 16'd2);
    repeat (3) send_sized(dcsg_pkg::ACT_TICK, '0, '0);
    wait_drained();
    repeat (3) send_sized(dcsg_pkg::ACT_TICK, '0, '0);
    send_sized(dcsg_pkg::ACT_INVERT, '0, '0);
    wait_drained();
  endtask

  // Watchdog: end the run once the cycle counter reaches the limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_cases();
    test_random_traffic(0, 0, 42);
    test_random_traffic(58, 0, 42);
    test_random_traffic(0, 58, 42);
    test_random_traffic(14, 14, 42);
    test_receiver_holdoff();
    test_drain_pause();
    // Catch any stray byte after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d actions (%0d producing bytes), %0d bytes checked,",
             actions_sent, busy_actions, bytes_checked);
    $display("%0d fills run to completion, under free flow, idle gaps, stalls and hold-off.",
             fills_done);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/dcsg_pkg.sv
design/dcsg_front.sv
design/dcsg_fifo.sv
design/dcsg_back.sv
design/display_command_stream_generator.sv
tb/testbench.sv
